// ===== rtl/core/bdg_pkg.sv =====
// Shared types and constants of the backward-difference gradient block.
// Used by the stream interfaces and by the top level; depends on nothing.
package bdg_pkg;

	// channel and gray values
	typedef logic [7:0] chan_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GRADIENT_MODE = 1'd0;
	localparam cfg_idx_t CFG_LINE_WIDTH    = 1'd1;

	// register widths and reset values
	localparam int LINE_W = 12;
	localparam int CFG_DATA_W = LINE_W;
	typedef logic [1:0] mode_t;
	typedef logic [LINE_W-1:0] line_t;
	localparam mode_t MODE_RESET = 2'd2;
	localparam line_t LINE_RESET = 12'd512;

	// gradient modes
	localparam mode_t MODE_DX  = 2'd0;
	localparam mode_t MODE_DY  = 2'd1;
	localparam mode_t MODE_SUM = 2'd2;
	localparam mode_t MODE_DIR = 2'd3;

	// output levels
	localparam chan_t LEVEL_MAX = 8'd255;
	localparam chan_t DIR_FLAT  = 8'd0;
	localparam chan_t DIR_STEEP = 8'd1;

	// gray weights, sum shifted right by GRAY_SHIFT
	localparam int GRAY_SUM_W = 13;
	localparam int GRAY_SHIFT = 5;
	localparam logic [GRAY_SUM_W-1:0] W_RED   = 13'd11;
	localparam logic [GRAY_SUM_W-1:0] W_GREEN = 13'd16;
	localparam logic [GRAY_SUM_W-1:0] W_BLUE  = 13'd5;

endpackage

// ===== rtl/core/bdg_pix_if.sv =====
// Pixel input stream: valid/ready handshake with an RGBA word and a frame mark.
// Depends on bdg_pkg.
interface bdg_pix_if;
	logic          valid;
	logic          ready;
	bdg_pkg::chan_t red;
	bdg_pkg::chan_t green;
	bdg_pkg::chan_t blue;
	bdg_pkg::chan_t alpha;
	logic          frame_start;

	modport source (output valid, red, green, blue, alpha, frame_start, input ready);
	modport sink   (input valid, red, green, blue, alpha, frame_start, output ready);
endinterface

// ===== rtl/core/bdg_edge_if.sv =====
// Edge result stream: valid/ready handshake with gradient level and alpha.
// Depends on bdg_pkg.
interface bdg_edge_if;
	logic          valid;
	logic          ready;
	bdg_pkg::chan_t edge_level;
	bdg_pkg::chan_t alpha_out;

	modport source (output valid, edge_level, alpha_out, input ready);
	modport sink   (input valid, edge_level, alpha_out, output ready);
endinterface

// ===== rtl/core/backward_difference_gradient.sv =====
// Backward-difference gradient: takes one RGBA pixel word per clock in raster order,
// a rate set by the single-port line buffer, while the output side is ready, and
// returns one edge word per pixel via the stage 1 and output registers. The line buffer
// is read and written at the same column in the cycle a pixel is accepted (read-first),
// so the row above is always current without forwarding. The line buffer holds
// MAX_WIDTH gray bytes and needs no clearing pass: the first row of a frame never uses
// it. gradient_mode selects |dx|, |dy|, |dx|+|dy| clamped to 255, or the direction
// class (255 if either difference is zero, 1 if |dy| >= 2|dx|, else 0). line_width of 0
// acts as 1 and values above MAX_WIDTH act as MAX_WIDTH. Write configuration only while
// no pixel is in flight. Depends on bdg_pkg, bdg_pix_if and bdg_edge_if.
module backward_difference_gradient #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bdg_pix_if.sink                         pix_in,
	bdg_edge_if.source                      edge_out,
	input  logic                            cfg_we,
	input  bdg_pkg::cfg_idx_t               cfg_index,
	input  logic [bdg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (EW > bdg_pkg::LINE_W) ? EW : bdg_pkg::LINE_W;
	localparam logic [XW-1:0] MAX_X = XW'(MAX_WIDTH);
	localparam int GRAY_SUM_W_L = bdg_pkg::GRAY_SUM_W;

	function automatic bdg_pkg::chan_t abs_diff(input bdg_pkg::chan_t a,
			input bdg_pkg::chan_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// configuration registers
	bdg_pkg::mode_t mode_q;
	bdg_pkg::line_t line_width_q;

	// position and left-neighbor state
	logic [CW-1:0]  col_q;
	logic           first_row_q;
	bdg_pkg::chan_t left_q;

	// stage 1: memory read in flight
	logic           valid_s1;
	bdg_pkg::chan_t gray_s1;
	bdg_pkg::chan_t ax_s1;
	bdg_pkg::chan_t alpha_s1;
	logic           first_row_s1;
	bdg_pkg::chan_t above_s1;

	// output register
	logic           out_valid_q;
	bdg_pkg::chan_t level_q;
	bdg_pkg::chan_t alpha_q;

	// line buffer
	bdg_pkg::chan_t row_mem [MAX_WIDTH];

	logic           accept;
	logic           adv_s1;
	logic [XW-1:0]  width_x;
	logic [CW-1:0]  cnt_start;
	logic           first_start;
	logic [CW-1:0]  col_acc;
	logic           first_acc;
	logic [XW-1:0]  next_x;
	logic [GRAY_SUM_W_L-1:0] gray_sum;
	bdg_pkg::chan_t gray_acc;
	bdg_pkg::chan_t ax_acc;
	bdg_pkg::chan_t ay_s1;
	logic [8:0]     sum_s1;
	bdg_pkg::chan_t level_s1;

	// handshake: stage 1 moves on when the output register is free or being taken
	assign adv_s1 = valid_s1 && (!out_valid_q || edge_out.ready);
	assign pix_in.ready = !valid_s1 || adv_s1;
	assign accept = pix_in.valid && pix_in.ready;

	// clamp the line width into 1..MAX_WIDTH
	always_comb begin
		width_x = XW'(line_width_q);
		if (width_x == '0) begin
			width_x = XW'(1);
		end else if (width_x > MAX_X) begin
			width_x = MAX_X;
		end
	end

	// locate the incoming pixel and the position of the next one
	always_comb begin
		cnt_start = pix_in.frame_start ? '0 : col_q;
		first_start = pix_in.frame_start ? 1'b1 : first_row_q;
		col_acc = cnt_start;
		first_acc = first_start;
		if (XW'(cnt_start) >= width_x) begin
			col_acc = '0;
			first_acc = 1'b0;
		end
		next_x = XW'(col_acc) + XW'(1);
	end

	// convert to gray and take the horizontal difference
	always_comb begin
		gray_sum = GRAY_SUM_W_L'(pix_in.red) * bdg_pkg::W_RED
			+ GRAY_SUM_W_L'(pix_in.green) * bdg_pkg::W_GREEN
			+ GRAY_SUM_W_L'(pix_in.blue) * bdg_pkg::W_BLUE;
		gray_acc = gray_sum[bdg_pkg::GRAY_SHIFT +: 8];
		ax_acc = (col_acc == '0) ? gray_acc : abs_diff(gray_acc, left_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bdg_pkg::MODE_RESET;
			line_width_q <= bdg_pkg::LINE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdg_pkg::CFG_GRADIENT_MODE: mode_q <= cfg_data[1:0];
				bdg_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the raster position and keep the left gray
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_row_q <= 1'b1;
			left_q <= '0;
		end else if (accept) begin
			left_q <= gray_acc;
			if (next_x >= width_x) begin
				col_q <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q <= next_x[CW-1:0];
				first_row_q <= first_acc;
			end
		end
	end

	// line buffer: read the row above and store this gray in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1 <= row_mem[col_acc];
			row_mem[col_acc] <= gray_acc;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= gray_acc;
			ax_s1 <= ax_acc;
			alpha_s1 <= pix_in.alpha;
			first_row_s1 <= first_acc;
		end
	end

	// vertical difference and mode selection
	always_comb begin
		ay_s1 = first_row_s1 ? gray_s1 : abs_diff(gray_s1, above_s1);
		sum_s1 = {1'b0, ax_s1} + {1'b0, ay_s1};
		case (mode_q)
			bdg_pkg::MODE_DX: level_s1 = ax_s1;
			bdg_pkg::MODE_DY: level_s1 = ay_s1;
			bdg_pkg::MODE_SUM: level_s1 = sum_s1[8] ? bdg_pkg::LEVEL_MAX : sum_s1[7:0];
			default: begin
				if (ax_s1 == '0 || ay_s1 == '0) begin
					level_s1 = bdg_pkg::LEVEL_MAX;
				end else if ({1'b0, ay_s1} >= {ax_s1, 1'b0}) begin
					level_s1 = bdg_pkg::DIR_STEEP;
				end else begin
					level_s1 = bdg_pkg::DIR_FLAT;
				end
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || edge_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			level_q <= level_s1;
			alpha_q <= alpha_s1;
		end
	end

	assign edge_out.valid = out_valid_q;
	assign edge_out.edge_level = level_q;
	assign edge_out.alpha_out = alpha_q;

	// an accepted word always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	// a stalled stage 1 keeps its line buffer data
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(above_s1) && $stable(gray_s1))
		else $error("stalled stage 1 lost its data");

	// a frame start on a row wider than one pixel leaves column 1 of the first row
	a_frame_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix_in.frame_start && width_x > XW'(1) |=> first_row_q && col_q == CW'(1))
		else $error("frame start did not restart the raster position");

	// direction mode only yields its three classes
	a_dir_codes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_q == bdg_pkg::MODE_DIR |->
			level_s1 == bdg_pkg::DIR_FLAT || level_s1 == bdg_pkg::DIR_STEEP
			|| level_s1 == bdg_pkg::LEVEL_MAX)
		else $error("direction class out of range");

endmodule

// ===== sim/backward_difference_gradient_tb.sv =====
// Testbench for backward_difference_gradient: pixel words in, edge words out, checked
// against a local gradient predictor. Depends on bdg_pkg, bdg_pix_if and bdg_edge_if.
`timescale 1ns / 1ps

module backward_difference_gradient_tb;

	localparam int LINE_DEPTH     = 2048;
	localparam int LIMIT_CYCLES   = 1000000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 10;
	localparam int PHASES         = 20;

	typedef struct packed {
		bdg_pkg::chan_t red;
		bdg_pkg::chan_t green;
		bdg_pkg::chan_t blue;
		bdg_pkg::chan_t alpha;
		logic           frame_start;
	} pix_word_t;

	typedef struct packed {
		bdg_pkg::chan_t level;
		bdg_pkg::chan_t alpha;
	} edge_word_t;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		bdg_pkg::cfg_idx_t idx;
		bdg_pkg::line_t    data;
		pix_word_t         pix;
		bit                typed;
		edge_word_t        want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	bdg_pkg::cfg_idx_t cfg_index;
	logic [bdg_pkg::CFG_DATA_W-1:0] cfg_data;

	bdg_pix_if  pix_bus ();
	bdg_edge_if edge_bus ();

	backward_difference_gradient #(
		.MAX_WIDTH(LINE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix_bus),
		.edge_out (edge_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state and register mirror
	bdg_pkg::chan_t gray_line [LINE_DEPTH];
	bit    line_written [LINE_DEPTH];
	int    left_gray;
	int    col_count;
	bit    first_row;
	bdg_pkg::mode_t mode_q;
	bdg_pkg::line_t width_q;
	bdg_pkg::mode_t mode_list [4] = '{bdg_pkg::MODE_DX, bdg_pkg::MODE_DY,
		bdg_pkg::MODE_SUM, bdg_pkg::MODE_DIR};

	edge_word_t level_q [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit squeeze = 1'b0;
	bit offering = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int eff_width();
		if (width_q == 0)
			return 1;
		if (width_q > LINE_DEPTH)
			return LINE_DEPTH;
		return int'(width_q);
	endfunction

	// column the next pixel lands in without a frame start; 1 if it reads the line
	function automatic bit reads_line(output int col);
		bit rf;
		col = col_count;
		rf = first_row;
		if (col >= eff_width()) begin
			col = 0;
			rf = 1'b0;
		end
		return !rf;
	endfunction

	// advance the gradient state by one pixel and return its edge word
	function automatic edge_word_t gradient_predict(pix_word_t p);
		int w, col, gray, ax, ay, lvl;
		edge_word_t r;
		w = eff_width();
		if (p.frame_start) begin
			col_count = 0;
			first_row = 1'b1;
		end
		if (col_count >= w) begin
			col_count = 0;
			first_row = 1'b0;
		end
		col = col_count;
		gray = (int'(p.red) * 11 + int'(p.green) * 16 + int'(p.blue) * 5) >> 5;
		if (col == 0)
			ax = gray;
		else
			ax = (gray >= left_gray) ? gray - left_gray : left_gray - gray;
		if (first_row)
			ay = gray;
		else
			ay = (gray >= gray_line[col]) ? gray - gray_line[col] : gray_line[col] - gray;
		case (mode_q)
			bdg_pkg::MODE_DX: lvl = ax;
			bdg_pkg::MODE_DY: lvl = ay;
			bdg_pkg::MODE_SUM:
				lvl = (ax + ay > bdg_pkg::LEVEL_MAX) ? bdg_pkg::LEVEL_MAX : ax + ay;
			default: begin
				if (ax == 0 || ay == 0)
					lvl = bdg_pkg::LEVEL_MAX;
				else
					lvl = (ay >= 2 * ax) ? bdg_pkg::DIR_STEEP : bdg_pkg::DIR_FLAT;
			end
		endcase
		gray_line[col] = bdg_pkg::chan_t'(gray);
		line_written[col] = 1'b1;
		left_gray = gray;
		col_count = col + 1;
		if (col_count >= w) begin
			col_count = 0;
			first_row = 1'b0;
		end
		r.level = bdg_pkg::chan_t'(lvl);
		r.alpha = p.alpha;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random pixel: noise, flat gray near a neighbor, random flat gray, or channel extremes
	function automatic pix_word_t gen_pixel();
		pix_word_t p;
		int kind, c, base, v;
		kind = $urandom_range(0, 9);
		p.alpha = bdg_pkg::chan_t'($urandom);
		p.frame_start = ($urandom_range(0, 59) == 0);
		if (kind < 4) begin
			p.red = bdg_pkg::chan_t'($urandom);
			p.green = bdg_pkg::chan_t'($urandom);
			p.blue = bdg_pkg::chan_t'($urandom);
		end else if (kind < 7) begin
			base = left_gray;
			if (reads_line(c) && line_written[c] && $urandom_range(0, 1))
				base = gray_line[c];
			v = base + $urandom_range(0, 8) - 4;
			v = (v < 0) ? 0 : (v > bdg_pkg::LEVEL_MAX) ? bdg_pkg::LEVEL_MAX : v;
			p.red = bdg_pkg::chan_t'(v);
			p.green = bdg_pkg::chan_t'(v);
			p.blue = bdg_pkg::chan_t'(v);
		end else if (kind == 7) begin
			p.red = $urandom_range(0, 1) ? bdg_pkg::LEVEL_MAX : '0;
			p.green = $urandom_range(0, 1) ? bdg_pkg::LEVEL_MAX : '0;
			p.blue = $urandom_range(0, 1) ? bdg_pkg::LEVEL_MAX : '0;
		end else begin
			v = $urandom_range(0, 255);
			p.red = bdg_pkg::chan_t'(v);
			p.green = bdg_pkg::chan_t'(v);
			p.blue = bdg_pkg::chan_t'(v);
		end
		// restart the frame rather than read a line entry never written
		if (!p.frame_start && reads_line(c) && !line_written[c])
			p.frame_start = 1'b1;
		return p;
	endfunction

	function automatic script_row_t cfg_row(bdg_pkg::cfg_idx_t idx, bdg_pkg::line_t data);
		script_row_t r;
		r = '{kind: ROW_CFG, idx: idx, data: data, pix: '0, typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic script_row_t pix_row(int red, int green, int blue, int alpha,
			bit fs, bit typed = 1'b0, int lvl = 0);
		script_row_t r;
		r = cfg_row(bdg_pkg::CFG_GRADIENT_MODE, '0);
		r.kind = ROW_PIX;
		r.pix = {bdg_pkg::chan_t'(red), bdg_pkg::chan_t'(green), bdg_pkg::chan_t'(blue),
			bdg_pkg::chan_t'(alpha), fs};
		r.typed = typed;
		r.want = {bdg_pkg::chan_t'(lvl), bdg_pkg::chan_t'(alpha)};
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("[%0t] %s: got %0d want %0d", $realtime, what, got, want);
	endtask

	task automatic lower_valid();
		if (offering) begin
			pix_bus.valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// wait for the block to go idle, then write one register
	task automatic write_reg(bdg_pkg::cfg_idx_t idx, bdg_pkg::line_t data);
		lower_valid();
		while (level_q.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == bdg_pkg::CFG_GRADIENT_MODE)
			mode_q = bdg_pkg::mode_t'(data[1:0]);
		else
			width_q = data;
		@(posedge clk);
	endtask

	// offer one pixel word, hold until taken, then queue its edge word
	task automatic send_pixel(pix_word_t p, bit typed, edge_word_t want);
		edge_word_t predicted;
		cfg_we <= 1'b0;
		pix_bus.red <= p.red;
		pix_bus.green <= p.green;
		pix_bus.blue <= p.blue;
		pix_bus.alpha <= p.alpha;
		pix_bus.frame_start <= p.frame_start;
		pix_bus.valid <= 1'b1;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!pix_bus.ready);
		predicted = gradient_predict(p);
		level_q.push_back(typed ? want : predicted);
		if (!calm && $urandom_range(0, 9) < 2) begin
			lower_valid();
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// check each accepted edge word against the oldest expectation
	always @(posedge clk) begin
		edge_word_t exp_word;
		if (arst_n === 1'b1 && edge_bus.valid && edge_bus.ready) begin
			if (level_q.size() == 0) begin
				report_mismatch("edge word with none expected", edge_bus.edge_level, 0);
			end else begin
				exp_word = level_q.pop_front();
				if (edge_bus.edge_level !== exp_word.level)
					report_mismatch("edge_level", edge_bus.edge_level, exp_word.level);
				if (edge_bus.alpha_out !== exp_word.alpha)
					report_mismatch("alpha_out", edge_bus.alpha_out, exp_word.alpha);
			end
		end
	end

	// receiver: random stalls, and one long hold-off on request
	initial begin : edge_drain
		int hold;
		edge_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze) begin
				edge_bus.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze = 1'b0;
				edge_bus.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) < 3) begin
				edge_bus.ready <= 1'b0;
				hold = gap_len();
				repeat (hold) @(posedge clk);
				edge_bus.ready <= 1'b1;
			end else begin
				edge_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : pixel_feed
		script_row_t script [$];
		int items;
		bdg_pkg::line_t w;
		bdg_pkg::mode_t m;

		// drive everything known, hold reset
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bdg_pkg::CFG_GRADIENT_MODE;
		cfg_data <= '0;
		pix_bus.valid <= 1'b0;
		pix_bus.red <= '0;
		pix_bus.green <= '0;
		pix_bus.blue <= '0;
		pix_bus.alpha <= '0;
		pix_bus.frame_start <= 1'b0;
		mode_q = bdg_pkg::MODE_RESET;
		width_q = bdg_pkg::LINE_RESET;
		col_count = 0;
		first_row = 1'b1;
		left_gray = 0;
		foreach (line_written[i])
			line_written[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, narrow and clamped widths, every mode
		script.push_back(pix_row(255, 255, 255, 0, 1'b1, 1'b1, bdg_pkg::LEVEL_MAX));
		script.push_back(pix_row(0, 0, 0, 255, 1'b0, 1'b1, bdg_pkg::LEVEL_MAX));
		script.push_back(cfg_row(bdg_pkg::CFG_GRADIENT_MODE,
			bdg_pkg::line_t'(bdg_pkg::MODE_DX)));
		script.push_back(cfg_row(bdg_pkg::CFG_LINE_WIDTH, bdg_pkg::line_t'(0)));
		script.push_back(pix_row(255, 0, 0, 17, 1'b1));
		script.push_back(pix_row(0, 255, 0, 200, 1'b0));
		script.push_back(cfg_row(bdg_pkg::CFG_GRADIENT_MODE,
			bdg_pkg::line_t'(bdg_pkg::MODE_DY)));
		script.push_back(pix_row(0, 0, 255, 85, 1'b0));
		script.push_back(pix_row(0, 0, 0, 170, 1'b1, 1'b1, 0));
		script.push_back(cfg_row(bdg_pkg::CFG_LINE_WIDTH, bdg_pkg::line_t'(4095)));
		script.push_back(cfg_row(bdg_pkg::CFG_GRADIENT_MODE,
			bdg_pkg::line_t'(bdg_pkg::MODE_SUM)));
		script.push_back(pix_row(128, 128, 128, 1, 1'b1, 1'b1, bdg_pkg::LEVEL_MAX));
		script.push_back(pix_row(127, 127, 127, 254, 1'b0));
		script.push_back(cfg_row(bdg_pkg::CFG_LINE_WIDTH, bdg_pkg::line_t'(2)));
		script.push_back(cfg_row(bdg_pkg::CFG_GRADIENT_MODE,
			bdg_pkg::line_t'(bdg_pkg::MODE_DIR)));
		script.push_back(pix_row(0, 0, 0, 66, 1'b1, 1'b1, bdg_pkg::LEVEL_MAX));
		script.push_back(pix_row(40, 40, 40, 99, 1'b0));
		script.push_back(pix_row(100, 100, 100, 3, 1'b0));
		script.push_back(pix_row(110, 110, 110, 128, 1'b0));
		// widen the width, then shrink it while a row is open
		script.push_back(cfg_row(bdg_pkg::CFG_LINE_WIDTH, bdg_pkg::line_t'(4)));
		script.push_back(cfg_row(bdg_pkg::CFG_GRADIENT_MODE,
			bdg_pkg::line_t'(bdg_pkg::MODE_SUM)));
		script.push_back(pix_row(10, 20, 30, 11, 1'b1));
		script.push_back(pix_row(255, 255, 255, 22, 1'b0));
		script.push_back(pix_row(0, 128, 255, 33, 1'b0));
		script.push_back(pix_row(200, 100, 50, 44, 1'b0));
		script.push_back(pix_row(12, 24, 36, 55, 1'b0));
		script.push_back(pix_row(250, 240, 230, 66, 1'b0));
		script.push_back(pix_row(5, 130, 250, 77, 1'b0));
		script.push_back(cfg_row(bdg_pkg::CFG_LINE_WIDTH, bdg_pkg::line_t'(2)));
		script.push_back(pix_row(60, 60, 60, 88, 1'b0));
		script.push_back(pix_row(61, 61, 61, 99, 1'b0));
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG)
				write_reg(script[i].idx, script[i].data);
			else
				send_pixel(script[i].pix, script[i].typed, script[i].want);
		end

		// random phases, each with its own mode and width
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				4: w = bdg_pkg::line_t'(0);
				8: w = bdg_pkg::line_t'(4095);
				12: w = bdg_pkg::line_t'(LINE_DEPTH);
				16: w = bdg_pkg::line_t'(LINE_DEPTH - 1);
				18: w = bdg_pkg::line_t'(1);
				default: begin
					if ($urandom_range(0, 4) == 0)
						w = bdg_pkg::line_t'($urandom_range(25, 300));
					else
						w = bdg_pkg::line_t'($urandom_range(2, 24));
				end
			endcase
			m = (ph < 8) ? mode_list[ph % 4] : mode_list[$urandom_range(0, 3)];
			items = (w > 300) ? 35 : 75;
			if ($urandom_range(0, 1)) begin
				write_reg(bdg_pkg::CFG_GRADIENT_MODE, bdg_pkg::line_t'(m));
				write_reg(bdg_pkg::CFG_LINE_WIDTH, w);
			end else begin
				write_reg(bdg_pkg::CFG_LINE_WIDTH, w);
				write_reg(bdg_pkg::CFG_GRADIENT_MODE, bdg_pkg::line_t'(m));
			end
			calm = (ph % 5 == 2) || (ph == 1);
			// fill the block against a stalled receiver
			if (ph == 1)
				squeeze = 1'b1;
			repeat (items)
				send_pixel(gen_pixel(), 1'b0, '0);
		end

		// let the last edge words out
		lower_valid();
		while (level_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
